// ----- hdl/bilateral_filter_5x5_depth_top_defines.svh -----
// Assertion helpers for the filter's top module.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef BILATERAL_FILTER_5X5_DEPTH_TOP_DEFINES_SVH
`define BILATERAL_FILTER_5X5_DEPTH_TOP_DEFINES_SVH

// Same-cycle implication.
`define BFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bfd_pkg.sv -----
package bfd_pkg;

    localparam int ACC_W      = 48;
    localparam int QUO_W      = 16;
    localparam int DEPTH_W    = 16;
    localparam int SP_W       = 16;
    localparam int TW_W       = 23;
    localparam int RADIUS     = 2;
    localparam int TAP_LAST   = 2 * RADIUS;
    localparam int CNT_W      = 4;
    localparam logic [15:0] GAUSS_ONE = 16'd32768;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_RANGE_SIGMA  = 3'd2,
        REG_GAUSS_W0     = 3'd3,
        REG_GAUSS_W1     = 3'd4,
        REG_GAUSS_W2     = 3'd5,
        REG_GAUSS_W3     = 3'd6,
        REG_GAUSS_W4     = 3'd7
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PWR,
        ST_SIG,
        ST_DEN,
        ST_FADDR,
        ST_FDATA,
        ST_SQ,
        ST_NST,
        ST_CHK,
        ST_TDIV,
        ST_ROMD,
        ST_SE,
        ST_ACC,
        ST_QSTART,
        ST_QWAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] top_bit;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

    // Ratio between neighboring exp table entries in Q0.32, from a Taylor series.
    function automatic logic [31:0] exp_ratio(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] r;
        term = 64'd1 << 32;
        r    = 64'd1 << 32;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x) >> 32) / 64'(n);
            if ((n & 1) == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        return r[31:0];
    endfunction

endpackage

// ----- hdl/bfd_line_store.sv -----
module bfd_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [bfd_pkg::DEPTH_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [bfd_pkg::DEPTH_W-1:0] rd_data
);

    logic [bfd_pkg::DEPTH_W-1:0] mem [DEPTH];
    logic [bfd_pkg::DEPTH_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/bfd_exp_rom.sv -----
module bfd_exp_rom #(
    parameter int          DEPTH = 256,
    parameter int          AW    = 8,
    parameter logic [31:0] RATIO = 32'd0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    output logic          ready
);

    logic [15:0]   mem [DEPTH];
    logic [15:0]   rd_data_reg;
    logic [32:0]   cur_reg;
    logic [32:0]   cur_next;
    logic [AW-1:0] idx_reg;
    logic          busy_reg;
    logic [16:0]   rounded;
    logic [15:0]   entry;
    logic [64:0]   prod;

    // Entries decay geometrically: each one is the previous times RATIO.
    always_comb begin
        rounded  = 17'((cur_reg + 33'd32768) >> 16);
        entry    = (rounded > 17'd65535) ? 16'hFFFF : rounded[15:0];
        prod     = 65'(cur_reg) * 65'(RATIO);
        cur_next = 33'(prod >> 32);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            cur_reg  <= 33'h1_0000_0000;
        end else if (busy_reg) begin
            cur_reg <= cur_next;
            if (idx_reg == AW'(DEPTH - 1)) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[idx_reg] <= entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !busy_reg;

endmodule

// ----- hdl/bfd_divider.sv -----
module bfd_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bfd_pkg::div_req_t         req,
    input  logic [bfd_pkg::ACC_W-1:0] dividend,
    input  logic [bfd_pkg::ACC_W-1:0] divisor,
    output bfd_pkg::div_rsp_t         rsp
);

    logic [bfd_pkg::ACC_W-1:0] rem_reg;
    logic [bfd_pkg::ACC_W-1:0] dsr_reg;
    logic [bfd_pkg::QUO_W-1:0] quo_reg;
    logic [bfd_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [63:0]               trial;
    logic                      fits;

    // Restoring division, one quotient bit per cycle from the top bit down.
    always_comb begin
        trial = 64'(dsr_reg) << cnt_reg;
        fits  = 64'(rem_reg) >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
            cnt_reg <= req.top_bit;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg          <= rem_reg - trial[bfd_pkg::ACC_W-1:0];
                quo_reg[cnt_reg] <= 1'b1;
            end
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// ----- hdl/bilateral_filter_5x5_depth_top.sv -----
// 5x5 bilateral filter for a raster stream of Q4.12 depth words.
// Input channel s_*: each word is a depth pixel (s_kind = 0) or a drain tick (s_kind = 1).
// Pixels fill a four-row line store; an output word is produced once the pixel two rows
// and up to two columns ahead has arrived. After a frame's last pixel, drain ticks flush the
// remaining output words, one per tick. Output channel m_*: the filtered depth, with
// m_frame_end set on the frame's last pixel.
// Each output word walks the 25 taps through one shared restoring divider (range-table
// index, then the final weighted mean) under a small sequencer. A tap whose range index
// falls off the table skips the divide and the table read. The final divide is 16 bits wide.
// s_ready is low while an item is being worked on. The finished word sits in an output
// register, so the next input word is accepted while that result waits for m_ready; a new
// result waits only if the previous one has still not been taken.
// After reset the range table is built, and no input word is accepted until it is done;
// configuration writes on the APB port are taken at any time.
// Reset clears the position counters and restores the register defaults.
`include "bilateral_filter_5x5_depth_top_defines.svh"

module bilateral_filter_5x5_depth_top #(
    parameter int MAX_WIDTH       = 512,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_depth_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_filtered_depth,
    output logic        m_frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SA_W   = $clog2(4 * MAX_WIDTH);
    localparam int ROM_AW = $clog2(EXP_TABLE_DEPTH);
    localparam int POS_W  = 21;
    localparam int N_W    = 32 + ROM_AW + 1;
    localparam int DL_W   = 36 + ROM_AW + 1;
    localparam logic [63:0] EXP_STEP  = (64'd8 << 32) / EXP_TABLE_DEPTH;
    localparam logic [31:0] EXP_RATIO = bfd_pkg::exp_ratio(EXP_STEP);

    // Configuration registers.
    logic [9:0]  fw_reg;
    logic [9:0]  fh_reg;
    logic [15:0] sigma_reg;
    logic [15:0] gw_reg [5];

    // Values in effect after the out-of-range fixups.
    logic [9:0]  w_eff;
    logic [9:0]  h_eff;
    logic [15:0] sig_eff;
    logic [15:0] gsat [5];

    bfd_pkg::state_t state_reg;
    bfd_pkg::state_t state_next;

    logic [COL_W-1:0] in_col_reg;
    logic [9:0]       in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [9:0]       out_row_reg;

    logic [15:0]      depth_reg;
    logic [POS_W-1:0] last_reg;
    logic [15:0]      evict_reg [8];
    logic [31:0]      sig2_reg;
    logic [35:0]      den_reg;
    logic [DL_W-1:0]  dlim_reg;
    logic             center_reg;
    logic [2:0]       tx_reg;
    logic [2:0]       ty_reg;
    logic             use_store_reg;
    logic [2:0]       ev_idx_reg;
    logic [bfd_pkg::SP_W-1:0] sp_reg;
    logic [15:0]      c_reg;
    logic [15:0]      d_reg;
    logic [31:0]      sq_reg;
    logic [N_W-1:0]   n_reg;
    logic [15:0]      e_reg;
    logic [bfd_pkg::TW_W-1:0]  tw_reg;
    logic [bfd_pkg::ACC_W-1:0] ws_reg;
    logic [bfd_pkg::ACC_W-1:0] wsum_reg;
    logic [15:0]      res_reg;

    logic        m_valid_reg;
    logic [15:0] m_depth_reg;
    logic        m_fend_reg;

    // Combinational helpers.
    logic             is_pixel;
    logic [POS_W-1:0] last_calc;
    logic [SA_W-1:0]  slot_addr;
    logic [POS_W-1:0] opos;
    logic [10:0]      lag;
    logic             emit;
    logic [2:0]       ev_w_idx;
    logic [2:0]       off_x;
    logic [2:0]       off_y;
    logic [11:0]      cx;
    logic [11:0]      cy;
    logic [11:0]      rsum;
    logic [11:0]      csum;
    logic [11:0]      rtap;
    logic [11:0]      ctap;
    logic [POS_W-1:0] ptap;
    logic [SA_W-1:0]  tap_addr;
    logic [15:0]      fetch_val;
    logic [15:0]      diff;
    logic             out_of_table;
    logic             fend;
    logic [11:0]      col_inc;
    logic             load_out;

    logic             st_we;
    logic [SA_W-1:0]  st_rd_addr;
    logic [15:0]      st_rd_data;
    logic [15:0]      rom_data;
    logic             rom_ready;

    bfd_pkg::div_req_t         div_req;
    bfd_pkg::div_rsp_t         div_rsp;
    logic [bfd_pkg::ACC_W-1:0] div_dividend;
    logic [bfd_pkg::ACC_W-1:0] div_divisor;

    // ---------------------------------------------------------------- APB port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg    <= 10'd320;
            fh_reg    <= 10'd240;
            sigma_reg <= 16'd410;
            gw_reg[0] <= 16'd8192;
            gw_reg[1] <= 16'd24576;
            gw_reg[2] <= 16'd32768;
            gw_reg[3] <= 16'd24576;
            gw_reg[4] <= 16'd8192;
        end else if (psel && penable && pwrite) begin
            case (bfd_pkg::reg_index_t'(paddr[4:2]))
                bfd_pkg::REG_FRAME_WIDTH:  fw_reg    <= pwdata[9:0];
                bfd_pkg::REG_FRAME_HEIGHT: fh_reg    <= pwdata[9:0];
                bfd_pkg::REG_RANGE_SIGMA:  sigma_reg <= pwdata[15:0];
                bfd_pkg::REG_GAUSS_W0:     gw_reg[0] <= pwdata[15:0];
                bfd_pkg::REG_GAUSS_W1:     gw_reg[1] <= pwdata[15:0];
                bfd_pkg::REG_GAUSS_W2:     gw_reg[2] <= pwdata[15:0];
                bfd_pkg::REG_GAUSS_W3:     gw_reg[3] <= pwdata[15:0];
                bfd_pkg::REG_GAUSS_W4:     gw_reg[4] <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (bfd_pkg::reg_index_t'(paddr[4:2]))
            bfd_pkg::REG_FRAME_WIDTH:  prdata = 32'(fw_reg);
            bfd_pkg::REG_FRAME_HEIGHT: prdata = 32'(fh_reg);
            bfd_pkg::REG_RANGE_SIGMA:  prdata = 32'(sigma_reg);
            bfd_pkg::REG_GAUSS_W0:     prdata = 32'(gw_reg[0]);
            bfd_pkg::REG_GAUSS_W1:     prdata = 32'(gw_reg[1]);
            bfd_pkg::REG_GAUSS_W2:     prdata = 32'(gw_reg[2]);
            bfd_pkg::REG_GAUSS_W3:     prdata = 32'(gw_reg[3]);
            bfd_pkg::REG_GAUSS_W4:     prdata = 32'(gw_reg[4]);
            default:                   prdata = '0;
        endcase
    end

    // A zero width or height acts as one, and the width is capped at the line store's row length.
    // A zero sigma acts as one, and spatial weights above unity saturate.
    always_comb begin
        if (fw_reg == 10'd0) begin
            w_eff = 10'd1;
        end else if (32'(fw_reg) > MAX_WIDTH) begin
            w_eff = 10'(MAX_WIDTH);
        end else begin
            w_eff = fw_reg;
        end
        h_eff   = (fh_reg == 10'd0) ? 10'd1 : fh_reg;
        sig_eff = (sigma_reg == 16'd0) ? 16'd1 : sigma_reg;
        for (int i = 0; i < 5; i++) begin
            gsat[i] = (gw_reg[i] > bfd_pkg::GAUSS_ONE) ? bfd_pkg::GAUSS_ONE : gw_reg[i];
        end
    end

    // ------------------------------------------------------------ position logic
    always_comb begin
        is_pixel  = !s_kind && (in_row_reg < h_eff);
        last_calc = is_pixel ?
                    POS_W'(in_row_reg) * POS_W'(w_eff) + POS_W'(in_col_reg) :
                    POS_W'(h_eff) * POS_W'(w_eff) - POS_W'(1);
        slot_addr = SA_W'(in_row_reg[1:0]) * SA_W'(MAX_WIDTH) + SA_W'(in_col_reg);
        opos      = POS_W'(out_row_reg) * POS_W'(w_eff) + POS_W'(out_col_reg);
        // Outputs trail the inputs by two rows and up to two columns.
        if (w_eff == 10'd1) begin
            lag = 11'(w_eff) << 1;
        end else if (w_eff == 10'd2) begin
            lag = (11'(w_eff) << 1) + 11'd1;
        end else begin
            lag = (11'(w_eff) << 1) + 11'd2;
        end
        emit     = last_reg >= opos + POS_W'(lag);
        ev_w_idx = last_reg[2:0] - {w_eff[0], 2'b00};
    end

    // Tap addressing with the window clamped at every image edge.
    always_comb begin
        off_x = center_reg ? 3'(bfd_pkg::RADIUS) : tx_reg;
        off_y = center_reg ? 3'(bfd_pkg::RADIUS) : ty_reg;
        cx    = (12'(out_col_reg) > 12'(w_eff) - 12'd1) ? 12'(w_eff) - 12'd1 : 12'(out_col_reg);
        cy    = (12'(out_row_reg) > 12'(h_eff) - 12'd1) ? 12'(h_eff) - 12'd1 : 12'(out_row_reg);
        rsum  = cy + 12'(off_y);
        csum  = cx + 12'(off_x);
        rtap  = (rsum < 12'(bfd_pkg::RADIUS)) ? 12'd0 : rsum - 12'(bfd_pkg::RADIUS);
        ctap  = (csum < 12'(bfd_pkg::RADIUS)) ? 12'd0 : csum - 12'(bfd_pkg::RADIUS);
        if (rtap > 12'(h_eff) - 12'd1) begin
            rtap = 12'(h_eff) - 12'd1;
        end
        if (ctap > 12'(w_eff) - 12'd1) begin
            ctap = 12'(w_eff) - 12'd1;
        end
        ptap     = POS_W'(rtap) * POS_W'(w_eff) + POS_W'(ctap);
        tap_addr = SA_W'(rtap[1:0]) * SA_W'(MAX_WIDTH) + SA_W'(ctap);
        // A slot already overwritten by the newest rows is served by the eviction buffer.
        fetch_val    = use_store_reg ? st_rd_data : evict_reg[ev_idx_reg];
        diff         = (d_reg > c_reg) ? d_reg - c_reg : c_reg - d_reg;
        out_of_table = DL_W'(n_reg) >= dlim_reg;
        fend         = (out_row_reg >= h_eff - 10'd1) &&
                       (12'(out_col_reg) >= 12'(w_eff) - 12'd1);
        col_inc      = 12'(out_col_reg) + 12'd1;
        load_out     = (state_reg == bfd_pkg::ST_FIN) && (!m_valid_reg || m_ready);
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        st_we           = 1'b0;
        st_rd_addr      = slot_addr;
        div_req.start   = 1'b0;
        div_req.top_bit = bfd_pkg::CNT_W'(ROM_AW - 1);
        div_dividend    = bfd_pkg::ACC_W'(n_reg);
        div_divisor     = bfd_pkg::ACC_W'(den_reg);
        case (state_reg)
            bfd_pkg::ST_IDLE: begin
                s_ready = rom_ready;
                if (s_valid && rom_ready) begin
                    if (is_pixel) begin
                        state_next = bfd_pkg::ST_PWR;
                    end else if (in_row_reg >= h_eff && out_row_reg < h_eff) begin
                        state_next = bfd_pkg::ST_SIG;
                    end
                end
            end
            bfd_pkg::ST_PWR: begin
                st_we      = 1'b1;
                state_next = emit ? bfd_pkg::ST_SIG : bfd_pkg::ST_IDLE;
            end
            bfd_pkg::ST_SIG:   state_next = bfd_pkg::ST_DEN;
            bfd_pkg::ST_DEN:   state_next = bfd_pkg::ST_FADDR;
            bfd_pkg::ST_FADDR: begin
                st_rd_addr = tap_addr;
                state_next = bfd_pkg::ST_FDATA;
            end
            bfd_pkg::ST_FDATA: begin
                state_next = center_reg ? bfd_pkg::ST_FADDR : bfd_pkg::ST_SQ;
            end
            bfd_pkg::ST_SQ:    state_next = bfd_pkg::ST_NST;
            bfd_pkg::ST_NST:   state_next = bfd_pkg::ST_CHK;
            bfd_pkg::ST_CHK: begin
                if (out_of_table) begin
                    state_next = bfd_pkg::ST_SE;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = bfd_pkg::ST_TDIV;
                end
            end
            bfd_pkg::ST_TDIV: begin
                if (div_rsp.done) begin
                    state_next = bfd_pkg::ST_ROMD;
                end
            end
            bfd_pkg::ST_ROMD:  state_next = bfd_pkg::ST_SE;
            bfd_pkg::ST_SE:    state_next = bfd_pkg::ST_ACC;
            bfd_pkg::ST_ACC: begin
                if (tx_reg == 3'(bfd_pkg::TAP_LAST) && ty_reg == 3'(bfd_pkg::TAP_LAST)) begin
                    state_next = bfd_pkg::ST_QSTART;
                end else begin
                    state_next = bfd_pkg::ST_FADDR;
                end
            end
            bfd_pkg::ST_QSTART: begin
                div_dividend    = ws_reg;
                div_divisor     = wsum_reg;
                div_req.top_bit = bfd_pkg::CNT_W'(bfd_pkg::QUO_W - 1);
                if (wsum_reg == '0) begin
                    state_next = bfd_pkg::ST_FIN;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = bfd_pkg::ST_QWAIT;
                end
            end
            bfd_pkg::ST_QWAIT: begin
                if (div_rsp.done) begin
                    state_next = bfd_pkg::ST_FIN;
                end
            end
            bfd_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = bfd_pkg::ST_IDLE;
                end
            end
            default: state_next = bfd_pkg::ST_IDLE;
        endcase
    end

    // ----------------------------------------------------------- position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (state_reg == bfd_pkg::ST_IDLE && s_valid && rom_ready && !is_pixel &&
                in_row_reg >= h_eff && out_row_reg >= h_eff) begin
                // A drain tick with nothing pending restarts the frame.
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else if (state_reg == bfd_pkg::ST_PWR) begin
                if (12'(in_col_reg) + 12'd1 >= 12'(w_eff)) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 10'd1;
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end else if (load_out) begin
                if (fend) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else if (col_inc >= 12'(w_eff)) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 10'd1;
                end else begin
                    out_col_reg <= COL_W'(col_inc);
                end
            end
        end
    end

    // ------------------------------------------------------------------ datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            bfd_pkg::ST_IDLE: begin
                if (s_valid && rom_ready) begin
                    depth_reg <= s_depth_in;
                    last_reg  <= last_calc;
                end
            end
            bfd_pkg::ST_PWR: begin
                evict_reg[ev_w_idx] <= st_rd_data;
            end
            bfd_pkg::ST_SIG: begin
                sig2_reg <= 32'(sig_eff) * 32'(sig_eff);
            end
            bfd_pkg::ST_DEN: begin
                den_reg    <= {sig2_reg, 4'b0000};
                dlim_reg   <= DL_W'(sig2_reg) * DL_W'(16 * EXP_TABLE_DEPTH);
                ws_reg     <= '0;
                wsum_reg   <= '0;
                tx_reg     <= '0;
                ty_reg     <= '0;
                center_reg <= 1'b1;
            end
            bfd_pkg::ST_FADDR: begin
                use_store_reg <= (ptap + (POS_W'(w_eff) << 2)) > last_reg;
                ev_idx_reg    <= ptap[2:0];
                sp_reg        <= bfd_pkg::SP_W'((32'(gsat[tx_reg]) * 32'(gsat[ty_reg])) >> 15);
            end
            bfd_pkg::ST_FDATA: begin
                if (center_reg) begin
                    c_reg      <= fetch_val;
                    center_reg <= 1'b0;
                end else begin
                    d_reg <= fetch_val;
                end
            end
            bfd_pkg::ST_SQ: begin
                sq_reg <= 32'(diff) * 32'(diff);
            end
            bfd_pkg::ST_NST: begin
                n_reg <= N_W'(sq_reg) * N_W'(EXP_TABLE_DEPTH);
            end
            bfd_pkg::ST_CHK: begin
                e_reg <= '0;
            end
            bfd_pkg::ST_ROMD: begin
                e_reg <= rom_data;
            end
            bfd_pkg::ST_SE: begin
                tw_reg <= bfd_pkg::TW_W'((32'(sp_reg) * 32'(e_reg)) >> 8);
            end
            bfd_pkg::ST_ACC: begin
                ws_reg   <= ws_reg + bfd_pkg::ACC_W'(tw_reg) * bfd_pkg::ACC_W'(d_reg);
                wsum_reg <= wsum_reg + bfd_pkg::ACC_W'(tw_reg);
                if (ty_reg == 3'(bfd_pkg::TAP_LAST)) begin
                    ty_reg <= '0;
                    tx_reg <= tx_reg + 3'd1;
                end else begin
                    ty_reg <= ty_reg + 3'd1;
                end
            end
            bfd_pkg::ST_QSTART: begin
                res_reg <= c_reg;
            end
            bfd_pkg::ST_QWAIT: begin
                if (div_rsp.done) begin
                    res_reg <= div_rsp.quot;
                end
            end
            default: begin
            end
        endcase
    end

    // --------------------------------------------------------------- output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_depth_reg <= res_reg;
            m_fend_reg  <= fend;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_depth = m_depth_reg;
    assign m_frame_end      = m_fend_reg;

    // --------------------------------------------------------------- submodules
    bfd_line_store #(
        .DEPTH(4 * MAX_WIDTH),
        .AW   (SA_W)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (st_we),
        .wr_addr(slot_addr),
        .wr_data(depth_reg),
        .rd_addr(st_rd_addr),
        .rd_data(st_rd_data)
    );

    bfd_exp_rom #(
        .DEPTH(EXP_TABLE_DEPTH),
        .AW   (ROM_AW),
        .RATIO(EXP_RATIO)
    ) u_exp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_addr(div_rsp.quot[ROM_AW-1:0]),
        .rd_data(rom_data),
        .ready  (rom_ready)
    );

    bfd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .rsp     (div_rsp)
    );

    // --------------------------------------------------------------- assertions
    `BFD_ASSERT_NXT(a_result_loaded, load_out, m_valid_reg, "finished word not presented")
    `BFD_ASSERT_IMP(a_div_done_waiting, div_rsp.done, (state_reg == bfd_pkg::ST_TDIV) || (state_reg == bfd_pkg::ST_QWAIT), "divider finished with nobody waiting")
    `BFD_ASSERT_IMP(a_center_first, state_reg == bfd_pkg::ST_SQ, !center_reg, "tap math started before the center pixel was fetched")

endmodule

// ----- dv/bilateral_filter_5x5_depth_top_test.sv -----
`timescale 1ns / 1ps

// Self-checking test of the 5x5 bilateral depth filter.
// Frames of depth words go in on the s_* channel. A predictor in this module keeps its own
// line store, range table and counters, and queues each filtered word that an accepted
// input may produce. Words leaving on the m_* channel are checked against that queue.
module bilateral_filter_5x5_depth_top_test;
    import bfd_pkg::*;

    localparam int LINE_LEN  = 512;
    localparam int RTAB_LEN  = 256;
    localparam int SETTLE    = 64;

    typedef struct {
        logic        kind;
        logic [15:0] depth;
    } depth_item_t;

    typedef struct {
        logic [15:0] depth;
        logic        fend;
    } filtered_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [15:0] s_depth_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_filtered_depth;
    logic        m_frame_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bilateral_filter_5x5_depth_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_depth_in(s_depth_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_filtered_depth(m_filtered_depth), .m_frame_end(m_frame_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 aclk = ~aclk;

    // Words waiting to be offered, and filtered words the block still owes us.
    depth_item_t    pending_words[$];
    filtered_word_t owed_words[$];
    int unsigned    words_queued = 0;
    int unsigned    err_count = 0;

    // Idle shaping. In burst mode neither side inserts random gaps, but a long hold still applies.
    bit          burst_mode = 1'b0;
    bit          long_hold_pending = 1'b0;
    int unsigned send_gap = 0;
    int unsigned ready_left = 0;
    int unsigned stall_left = 0;
    bit          s_took = 1'b0;

    // Predictor state: our own copy of the registers, line store and position counters.
    logic [9:0]  cfg_width = 10'd320;
    logic [9:0]  cfg_height = 10'd240;
    logic [15:0] cfg_sigma = 16'd410;
    logic [15:0] cfg_gauss [5] = '{16'd8192, 16'd24576, 16'd32768, 16'd24576, 16'd8192};
    logic [15:0] line_mem [4*LINE_LEN];
    logic [15:0] evicted_mem [8];
    int unsigned range_tab [RTAB_LEN];
    int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // The range table holds exp(-a) over [0, 8) in Q0.16. Each entry is the previous one
    // times a fixed ratio, where the ratio comes from a truncated Taylor series.
    function automatic void build_range_tab();
        longint unsigned step, term, ratio, cur, v;
        step  = (64'd8 << 32) / RTAB_LEN;
        term  = 64'd1 << 32;
        ratio = 64'd1 << 32;
        cur   = 64'd1 << 32;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * step) >> 32) / n;
            if (n % 2 == 1) ratio -= term; else ratio += term;
        end
        for (int k = 0; k < RTAB_LEN; k++) begin
            v = (cur + 32768) >> 16;
            range_tab[k] = (v > 65535) ? 65535 : int'(v);
            cur = (cur * ratio) >> 32;
        end
    endfunction

    function automatic longint unsigned gauss_sat(input int off);
        return (cfg_gauss[off + RADIUS] > GAUSS_ONE) ? 32768 : cfg_gauss[off + RADIUS];
    endfunction

    // A pixel four or more rows behind the newest one has been overwritten in the line
    // store, so it is taken from the small buffer of overwritten values.
    function automatic logic [15:0] tap_value(input int unsigned r, input int unsigned c,
                                              input int unsigned w, input int unsigned last_pos);
        int unsigned p;
        p = r * w + c;
        if (p + 4 * w > last_pos) return line_mem[(r % 4) * LINE_LEN + c];
        return evicted_mem[p % 8];
    endfunction

    function automatic int unsigned clamp_to(input int v, input int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [15:0] filter_at(input int unsigned ox, input int unsigned oy,
                                              input int unsigned w, input int unsigned h,
                                              input int unsigned last_pos);
        longint unsigned sig, den, sp, diff, k, e, tw, num_acc, wt_acc, q;
        int unsigned cx, cy, r, cc;
        logic [15:0] ctr, d;
        sig = (cfg_sigma == 0) ? 1 : cfg_sigma;
        den = sig * sig * 16;
        cx = clamp_to(ox, w - 1);
        cy = clamp_to(oy, h - 1);
        ctr = tap_value(cy, cx, w, last_pos);
        num_acc = 0;
        wt_acc = 0;
        for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
                r  = clamp_to(int'(cy) + dy, h - 1);
                cc = clamp_to(int'(cx) + dx, w - 1);
                d  = tap_value(r, cc, w, last_pos);
                sp = (gauss_sat(dx) * gauss_sat(dy)) >> 15;
                diff = (d > ctr) ? d - ctr : ctr - d;
                k  = diff * diff * RTAB_LEN / den;
                e  = (k < RTAB_LEN) ? range_tab[k] : 0;
                tw = (sp * e) >> 8;
                num_acc += tw * d;
                wt_acc  += tw;
            end
        end
        // With every weight at zero the center pixel passes through unchanged.
        if (wt_acc == 0) return ctr;
        q = num_acc / wt_acc;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic void clear_position();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    // Advances the predictor by one accepted word and queues the filtered word it owes.
    function automatic void predict_filtered(input logic kind, input logic [15:0] din);
        int unsigned w, h, lag, last_pos, opos, slot;
        bit emit, fend;
        filtered_word_t fw;
        w = (cfg_width == 0) ? 1 : ((cfg_width > LINE_LEN) ? LINE_LEN : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        lag = 2 * w + ((w - 1 < 2) ? w - 1 : 2);
        opos = out_row * w + out_col;
        if (kind == 1'b0 && in_row < h) begin
            slot = (in_row % 4) * LINE_LEN + in_col;
            last_pos = in_row * w + in_col;
            evicted_mem[(last_pos - 4 * w) % 8] = line_mem[slot];
            line_mem[slot] = din;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            emit = (last_pos >= opos + lag);
        end else begin
            // A drain before the frame's last pixel is dropped.
            if (in_row < h) return;
            if (out_row >= h) begin
                clear_position();
                return;
            end
            last_pos = h * w - 1;
            emit = 1'b1;
        end
        if (!emit) return;
        fw.depth = filter_at(out_col, out_row, w, h, last_pos);
        fend = (out_row >= h - 1) && (out_col >= w - 1);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (fend) clear_position();
        fw.fend = fend;
        owed_words.push_back(fw);
    endfunction

    // Sender. The next word is put up at the falling edge after the previous one was taken,
    // possibly after a random gap. At most one assignment to each signal per edge.
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) predict_filtered(s_kind, s_depth_in);
    end

    always @(negedge aclk) begin
        depth_item_t it;
        logic next_valid;
        next_valid = s_valid;
        if (!s_valid || s_took) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_words.size() > 0) begin
                it = pending_words.pop_front();
                s_kind <= it.kind;
                s_depth_in <= it.depth;
                next_valid = 1'b1;
                if (!burst_mode) begin
                    case ($urandom_range(0, 19))
                        0:               send_gap = $urandom_range(15, 80);
                        1, 2, 3, 4, 5:   send_gap = $urandom_range(1, 3);
                        default:         send_gap = 0;
                    endcase
                end
            end
        end
        s_valid <= next_valid;
    end

    // Receiver. Ready alternates between runs of high and low cycles. A requested long
    // hold keeps it low for a long stretch so the block backs up into its input.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stall_left = 3000;
            m_ready <= 1'b0;
        end else if (burst_mode) begin
            m_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left--;
        end else if (!m_ready) begin
            m_ready <= 1'b1;
            ready_left = $urandom_range(0, 20);
        end else begin
            m_ready <= 1'b0;
            case ($urandom_range(0, 19))
                0:       ready_left = $urandom_range(30, 150);
                1, 2:    ready_left = $urandom_range(4, 10);
                default: ready_left = $urandom_range(0, 2);
            endcase
        end
    end

    // Checker: every word taken from the output must match the oldest owed word.
    always @(posedge aclk) begin
        filtered_word_t fw;
        if (aresetn && m_valid && m_ready) begin
            if (owed_words.size() == 0) begin
                report("unexpected word, depth", m_filtered_depth, 0);
            end else begin
                fw = owed_words.pop_front();
                if (m_filtered_depth !== fw.depth) report("filtered_depth", m_filtered_depth, fw.depth);
                if (m_frame_end !== fw.fend) report("frame_end", m_frame_end, fw.fend);
            end
        end
    end

    // One APB write: setup cycle, then access cycle. The register takes the value at the
    // rising edge of the access cycle, so the predictor copy is updated there too.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width = value[9:0];
            REG_FRAME_HEIGHT: cfg_height = value[9:0];
            REG_RANGE_SIGMA:  cfg_sigma = value[15:0];
            REG_GAUSS_W0:     cfg_gauss[0] = value[15:0];
            REG_GAUSS_W1:     cfg_gauss[1] = value[15:0];
            REG_GAUSS_W2:     cfg_gauss[2] = value[15:0];
            REG_GAUSS_W3:     cfg_gauss[3] = value[15:0];
            REG_GAUSS_W4:     cfg_gauss[4] = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_weights(input logic [15:0] a, input logic [15:0] b,
                                 input logic [15:0] c);
        write_reg(REG_GAUSS_W0, a);
        write_reg(REG_GAUSS_W1, b);
        write_reg(REG_GAUSS_W2, c);
        write_reg(REG_GAUSS_W3, b);
        write_reg(REG_GAUSS_W4, a);
    endtask

    // Waits until every queued word was taken and every owed word came back. A word that
    // produces nothing may still be in flight, so a settling wait follows.
    task automatic wait_idle();
        wait (pending_words.size() == 0 && !s_valid && owed_words.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push_word(input logic kind, input logic [15:0] d);
        depth_item_t it;
        it.kind = kind;
        it.depth = d;
        pending_words.push_back(it);
        words_queued++;
    endtask

    // Queues a whole frame plus the drain words that flush it. Content styles:
    // 0 full-range noise, 1 smooth surface with small noise, 2 only the two extremes.
    // Some drains are sent as pixels, which the block treats as drains after the frame.
    task automatic queue_frame(input int unsigned fw, input int unsigned fh, input int style,
                               input bit early_drain);
        int unsigned w, h, lag, tail, base, spread, v;
        w = (fw == 0) ? 1 : ((fw > LINE_LEN) ? LINE_LEN : fw);
        h = (fh == 0) ? 1 : fh;
        lag = 2 * w + ((w - 1 < 2) ? w - 1 : 2);
        base = $urandom_range(0, 65535);
        spread = $urandom_range(1, 2048);
        for (int unsigned i = 0; i < w * h; i++) begin
            case (style)
                0: v = $urandom_range(0, 65535);
                1: begin
                    v = base + $urandom_range(0, 2 * spread);
                    v = (v < spread) ? 0 : v - spread;
                    if (v > 65535) v = 65535;
                end
                default: v = ($urandom_range(0, 1) == 1) ? 65535 : 0;
            endcase
            push_word(1'b0, v[15:0]);
            // A drain in the middle of a frame is ignored by the block.
            if (early_drain && i == (w * h) / 2) push_word(1'b1, $urandom_range(0, 65535));
        end
        tail = (w * h < lag) ? w * h : lag;
        for (int unsigned i = 0; i < tail; i++) begin
            push_word(($urandom_range(0, 3) != 0), $urandom_range(0, 65535));
        end
    endtask

    initial begin
        int unsigned fw, fh;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (evicted_mem[i]) evicted_mem[i] = '0;
        build_range_tab();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: a small frame at default weights with extreme depths, a mid-frame
        // drain that must be dropped, and a single-pixel frame.
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_RANGE_SIGMA, 410);
        queue_frame(4, 3, 2, 1'b1);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 1);
        queue_frame(1, 1, 0, 1'b0);
        wait_idle();

        // All spatial weights zero: every output is the center pixel. Zero sigma acts as one.
        write_weights(0, 0, 0);
        write_reg(REG_RANGE_SIGMA, 0);
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 2);
        queue_frame(3, 2, 0, 1'b0);
        wait_idle();

        // Weights above one saturate; the widest sigma keeps every tap on the table.
        write_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(REG_RANGE_SIGMA, 16'hFFFF);
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 0);
        queue_frame(2, 1, 0, 1'b0);
        wait_idle();

        // Widest and tallest register values. The tall one is left before it is used.
        write_reg(REG_FRAME_HEIGHT, 10'h3FF);
        write_reg(REG_FRAME_WIDTH, 10'h3FF);
        write_reg(REG_FRAME_HEIGHT, 1);
        write_weights(8192, 24576, 32768);
        write_reg(REG_RANGE_SIGMA, 410);
        burst_mode = 1'b1;
        queue_frame(10'h3FF, 1, 1, 1'b0);
        wait_idle();
        burst_mode = 1'b0;

        // Random part: small frames under random settings. One frame is run against a long
        // receiver hold while the sender keeps offering words.
        for (int n = 0; words_queued < 1500 + 900; n++) begin
            fw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            fh = $urandom_range(1, 6);
            write_reg(REG_FRAME_WIDTH, fw);
            write_reg(REG_FRAME_HEIGHT, fh);
            write_reg(REG_RANGE_SIGMA, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 65535) : $urandom_range(1, 4096));
            write_reg(REG_GAUSS_W0, $urandom_range(0, 32768));
            write_reg(REG_GAUSS_W1, $urandom_range(0, 32768));
            write_reg(REG_GAUSS_W2, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(32768, 65535) : $urandom_range(0, 32768));
            write_reg(REG_GAUSS_W3, $urandom_range(0, 32768));
            write_reg(REG_GAUSS_W4, $urandom_range(0, 32768));
            burst_mode = ($urandom_range(0, 5) == 0);
            if (n == 3) long_hold_pending = 1'b1;
            queue_frame(fw, fh, ($urandom_range(0, 4) == 0) ? 0 : 1, ($urandom_range(0, 5) == 0));
            wait_idle();
        end

        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bfd_pkg.sv
hdl/bfd_line_store.sv
hdl/bfd_exp_rom.sv
hdl/bfd_divider.sv
hdl/bilateral_filter_5x5_depth_top.sv
dv/bilateral_filter_5x5_depth_top_test.sv
